/* rtl/hne_pkg.sv */
// ----------------------------------------------------------------------------
// hne_pkg: shared types, constants and step functions
// Register indexes, per-stage state of the square root and divide pipelines.
// ----------------------------------------------------------------------------
package hne_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SCALE  = 2'd2;
	localparam logic [1:0] CFG_COS    = 2'd3;

	// Pipeline depth of the integer square root and the quotient loops
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 31;

	// Control that travels with a pixel
	typedef struct packed {
		logic       valid;
		logic [3:0] exist;
	} tri_ctl_t;

	// Square root state: remaining radicand and partial root
	typedef struct packed {
		logic [61:0] n;
		logic [61:0] r;
	} sqrt_st_t;

	// Restoring divide state: partial remainder and quotient
	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] quo;
	} div_st_t;

	// One digit of the square root for trial bit b
	function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [61:0] b);
		sqrt_st_t    o;
		logic [62:0] t;
		t = {1'b0, s.r} + {1'b0, b};
		if ({1'b0, s.n} >= t) begin
			o.n = s.n - t[61:0];
			o.r = (s.r >> 1) + b;
		end else begin
			o.n = s.n;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	// One quotient bit: shift in din, subtract the divisor when it fits
	function automatic div_st_t div_step(div_st_t s, logic din, logic [30:0] d);
		div_st_t     o;
		logic [32:0] t;
		logic        ge;
		t  = {s.rem, din};
		ge = (t >= {2'b00, d});
		if (ge) begin
			t = t - {2'b00, d};
		end
		o.rem = t[31:0];
		o.quo = {s.quo[29:0], ge};
		return o;
	endfunction

endpackage

/* rtl/hne_grad.sv */
// ----------------------------------------------------------------------------
// hne_grad: height gradients and triangle edge vectors
// Three stages: height differences and bound tests, scale multiply, signs.
// ----------------------------------------------------------------------------
module hne_grad (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [11:0]          col,
	input  logic [11:0]          row,
	input  logic [31:0]          z_center,
	input  logic [31:0]          z_up,
	input  logic [31:0]          z_down,
	input  logic [31:0]          z_left,
	input  logic [31:0]          z_right,
	input  logic [12:0]          image_width,
	input  logic [12:0]          image_height,
	input  logic [23:0]          vertical_scale,
	output hne_pkg::tri_ctl_t    ctl_o,
	output logic [3:0][1:0][56:0] grad_o
);
	import hne_pkg::*;

	logic signed [32:0] du_s1, dd_s1, dl_s1, dr_s1;
	logic [3:0]         ex_s1, ex_s2, ex_s3;
	logic               v_s1, v_s2, v_s3;
	logic signed [56:0] gu_s2, gd_s2, gl_s2, gr_s2;
	logic               left, up, right, down;

	// Bound tests against the configured image size
	always_comb begin
		left  = (col != 12'd0);
		up    = (row != 12'd0);
		right = (({1'b0, col} + 13'd1) < image_width);
		down  = (({1'b0, row} + 13'd1) < image_height);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Differences, products, then the four triangle vectors
	always_ff @(posedge clk) begin
		if (en) begin
			du_s1 <= $signed({z_up[31], z_up}) - $signed({z_center[31], z_center});
			dd_s1 <= $signed({z_down[31], z_down}) - $signed({z_center[31], z_center});
			dl_s1 <= $signed({z_left[31], z_left}) - $signed({z_center[31], z_center});
			dr_s1 <= $signed({z_right[31], z_right}) - $signed({z_center[31], z_center});
			ex_s1 <= {right & down, left & down, right & up, left & up};

			gu_s2 <= du_s1 * $signed({1'b0, vertical_scale});
			gd_s2 <= dd_s1 * $signed({1'b0, vertical_scale});
			gl_s2 <= dl_s1 * $signed({1'b0, vertical_scale});
			gr_s2 <= dr_s1 * $signed({1'b0, vertical_scale});
			ex_s2 <= ex_s1;

			ex_s3        <= ex_s2;
			grad_o[0][0] <= gl_s2;
			grad_o[0][1] <= gu_s2;
			grad_o[1][0] <= -gr_s2;
			grad_o[1][1] <= gu_s2;
			grad_o[2][0] <= gl_s2;
			grad_o[2][1] <= -gd_s2;
			grad_o[3][0] <= -gr_s2;
			grad_o[3][1] <= -gd_s2;
		end
	end

	assign ctl_o = '{valid: v_s3, exist: ex_s3};

endmodule

/* rtl/hne_unit.sv */
// ----------------------------------------------------------------------------
// hne_unit: pipelined vector normalizer
// Scales a 3-vector to Q2.30 unit length: magnitude, leading one, shift,
// squares, sum, bit-per-stage square root, bit-per-stage divides, sign.
// ----------------------------------------------------------------------------
module hne_unit #(
	parameter int IW = 57,
	parameter int SW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][IW-1:0]   in_v,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [2:0][31:0]     out_u,
	output logic                 out_nz,
	output logic [SW-1:0]        out_side
);
	import hne_pkg::*;

	localparam int PW = $clog2(IW);
	localparam int XW = IW + 30;
	localparam int CW = SW + 94;

	logic [2:0][IW-1:0] mag_a, mag_b;
	logic [2:0]         neg_a, neg_b, neg_c, neg_d;
	logic [SW-1:0]      side_a, side_b, side_c, side_d;
	logic               valid_a, valid_b, valid_c, valid_d;
	logic [PW-1:0]      pos_b;
	logic               nz_b, nz_c, nz_d;
	logic [2:0][29:0]   m_c, m_d;
	logic [2:0][59:0]   sq_d;

	logic [IW-1:0]      or_a;
	logic [PW-1:0]      lead;
	logic [2:0][29:0]   m_sh;
	logic [XW-1:0]      ext;
	logic [XW-1:0]      shv;

	sqrt_st_t           sq_q [0:SQRT_STEPS];
	logic [CW-1:0]      cs_q [0:SQRT_STEPS];
	logic               vs_q [0:SQRT_STEPS];

	div_st_t            dv_q [0:DIV_STEPS-1][3];
	logic [30:0]        rt_q [0:DIV_STEPS-1];
	logic [SW+3:0]      cd_q [0:DIV_STEPS-1];
	logic               vd_q [0:DIV_STEPS-1];

	logic [2:0][29:0]   m_e;
	logic [SW+3:0]      ctl_e;
	logic [SW+3:0]      ctl_f;
	logic [30:0]        root;

	// Leading one of the largest magnitude
	always_comb begin
		or_a = mag_a[0] | mag_a[1] | mag_a[2];
		lead = '0;
		for (int i = 0; i < IW; i++) begin
			if (or_a[i]) begin
				lead = PW'(i);
			end
		end
	end

	// Bring the largest magnitude into [2^29, 2^30)
	always_comb begin
		ext = '0;
		shv = '0;
		for (int k = 0; k < 3; k++) begin
			ext = XW'(mag_b[k]);
			if (int'(pos_b) >= 29) begin
				shv = ext >> (int'(pos_b) - 29);
			end else begin
				shv = ext << (29 - int'(pos_b));
			end
			m_sh[k] = shv[29:0];
		end
	end

	assign m_e   = cs_q[SQRT_STEPS][89:0];
	assign ctl_e = cs_q[SQRT_STEPS][CW-1:90];
	assign root  = sq_q[SQRT_STEPS].r[30:0];
	assign ctl_f = cd_q[DIV_STEPS-1];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a   <= 1'b0;
			valid_b   <= 1'b0;
			valid_c   <= 1'b0;
			valid_d   <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i <= SQRT_STEPS; i++) begin
				vs_q[i] <= 1'b0;
			end
			for (int i = 0; i < DIV_STEPS; i++) begin
				vd_q[i] <= 1'b0;
			end
		end else if (en) begin
			valid_a <= in_valid;
			valid_b <= valid_a;
			valid_c <= valid_b;
			valid_d <= valid_c;
			vs_q[0] <= valid_d;
			for (int i = 0; i < SQRT_STEPS; i++) begin
				vs_q[i+1] <= vs_q[i];
			end
			vd_q[0] <= vs_q[SQRT_STEPS];
			for (int i = 1; i < DIV_STEPS; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
			out_valid <= vd_q[DIV_STEPS-1];
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// magnitude and sign
			for (int k = 0; k < 3; k++) begin
				neg_a[k] <= in_v[k][IW-1];
				mag_a[k] <= in_v[k][IW-1] ? (IW'(0) - in_v[k]) : in_v[k];
			end
			side_a <= in_side;

			// leading one
			mag_b  <= mag_a;
			neg_b  <= neg_a;
			pos_b  <= lead;
			nz_b   <= (or_a != '0);
			side_b <= side_a;

			// shift
			m_c    <= m_sh;
			neg_c  <= neg_b;
			nz_c   <= nz_b;
			side_c <= side_b;

			// squares
			for (int k = 0; k < 3; k++) begin
				sq_d[k] <= m_c[k] * m_c[k];
			end
			m_d    <= m_c;
			neg_d  <= neg_c;
			nz_d   <= nz_c;
			side_d <= side_c;

			// sum of squares
			sq_q[0].n <= 62'(sq_d[0]) + 62'(sq_d[1]) + 62'(sq_d[2]);
			sq_q[0].r <= '0;
			cs_q[0]   <= {side_d, nz_d, neg_d, m_d};

			// square root, one root bit a stage
			for (int i = 0; i < SQRT_STEPS; i++) begin
				sq_q[i+1] <= sqrt_step(sq_q[i], 62'(1) << (2 * (SQRT_STEPS - 1 - i)));
				cs_q[i+1] <= cs_q[i];
			end

			// divide m * 2^30 by the root, one quotient bit a stage
			for (int k = 0; k < 3; k++) begin
				dv_q[0][k] <= div_step('{rem: 32'(m_e[k][29:1]), quo: 31'd0}, m_e[k][0], root);
			end
			rt_q[0] <= root;
			cd_q[0] <= ctl_e;
			for (int i = 1; i < DIV_STEPS; i++) begin
				for (int k = 0; k < 3; k++) begin
					dv_q[i][k] <= div_step(dv_q[i-1][k], 1'b0, rt_q[i-1]);
				end
				rt_q[i] <= rt_q[i-1];
				cd_q[i] <= cd_q[i-1];
			end

			// apply sign, force zero for a zero vector
			for (int k = 0; k < 3; k++) begin
				if (!ctl_f[3]) begin
					out_u[k] <= '0;
				end else if (ctl_f[k]) begin
					out_u[k] <= 32'd0 - 32'(dv_q[DIV_STEPS-1][k].quo);
				end else begin
					out_u[k] <= 32'(dv_q[DIV_STEPS-1][k].quo);
				end
			end
			out_nz   <= ctl_f[3];
			out_side <= ctl_f[SW+3:4];
		end
	end

endmodule

/* rtl/hne_accum.sv */
// ----------------------------------------------------------------------------
// hne_accum: triangle normal accumulator
// Two stages per triangle: dot products against the running sum, then the
// threshold test and conditional add. The first present triangle seeds the sum.
// ----------------------------------------------------------------------------
module hne_accum (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  hne_pkg::tri_ctl_t      ctl_i,
	input  logic [3:0][2:0][31:0]  tri_u,
	input  logic [15:0]            min_cosine,
	output logic                   out_valid,
	output logic                   out_has,
	output logic [2:0][33:0]       out_acc
);
	import hne_pkg::*;

	typedef struct packed {
		logic [3:0]            ex;
		logic                  started;
		logic [2:0][33:0]      acc;
		logic [3:0][2:0][31:0] t;
	} acc_st_t;

	acc_st_t            st_p [0:3];
	acc_st_t            st_s [0:3];
	acc_st_t            pin  [0:3];
	acc_st_t            nxt  [0:3];
	logic signed [65:0] prod_p [0:3][3];
	logic               vp [0:3];
	logic               vs [0:3];

	logic signed [65:0] dot;
	logic [65:0]        mag;
	logic [65:0]        thr;
	logic               pass;

	// Stage inputs: the pixel for the first pair, the previous pair otherwise
	always_comb begin
		pin[0].ex      = ctl_i.exist;
		pin[0].started = 1'b0;
		pin[0].acc     = '0;
		pin[0].t       = tri_u;
		for (int j = 1; j < 4; j++) begin
			pin[j] = st_s[j-1];
		end
	end

	// Threshold test and conditional add
	always_comb begin
		thr  = {21'd0, min_cosine[14:0], 30'd0} << 15;
		dot  = '0;
		mag  = '0;
		pass = 1'b0;
		for (int j = 0; j < 4; j++) begin
			nxt[j] = st_p[j];
			dot    = prod_p[j][0] + prod_p[j][1] + prod_p[j][2];
			mag    = dot[65] ? (66'd0 - dot) : dot;
			pass   = min_cosine[15] || (mag > thr);
			if (st_p[j].ex[j]) begin
				if (!st_p[j].started) begin
					nxt[j].started = 1'b1;
					for (int k = 0; k < 3; k++) begin
						nxt[j].acc[k] = {{2{st_p[j].t[j][k][31]}}, st_p[j].t[j][k]};
					end
				end else if (pass) begin
					for (int k = 0; k < 3; k++) begin
						nxt[j].acc[k] = st_p[j].acc[k]
							+ {{2{st_p[j].t[j][k][31]}}, st_p[j].t[j][k]};
					end
				end
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 4; j++) begin
				vp[j] <= 1'b0;
				vs[j] <= 1'b0;
			end
		end else if (en) begin
			vp[0] <= ctl_i.valid;
			vs[0] <= vp[0];
			for (int j = 1; j < 4; j++) begin
				vp[j] <= vs[j-1];
				vs[j] <= vp[j];
			end
		end
	end

	// Products, then the updated sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				st_p[j] <= pin[j];
				for (int k = 0; k < 3; k++) begin
					prod_p[j][k] <= $signed({{34{pin[j].t[j][k][31]}}, pin[j].t[j][k]})
						* $signed({{32{pin[j].acc[k][33]}}, pin[j].acc[k]});
				end
				st_s[j] <= nxt[j];
			end
		end
	end

	assign out_valid = vs[3];
	assign out_has   = st_s[3].started;
	assign out_acc   = st_s[3].acc;

endmodule

/* rtl/heightmap_normal_estimator_core.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_estimator_core: surface normal of an elevation image pixel
// Takes one pixel per cycle while no result is held at the output. A pixel
// passes through 3 gradient stages, the triangle normalizers, the accumulator,
// the final normalizer and one output register. Most of the latency comes from
// the bit-per-stage square root and divide pipelines inside each normalizer.
// The whole pipeline holds while a result waits at the output. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module heightmap_normal_estimator_core #(
	parameter int MAX_SIZE = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// col[11:0], row[23:12], z_center[55:24], z_up[87:56], z_down[119:88],
	// z_left[151:120], z_right[183:152]
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// normal_x[15:0], normal_y[31:16], normal_z[47:32]
	output logic [47:0]  m_axis_tdata,
	// has_normal[0]
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata
);
	import hne_pkg::*;

	localparam logic [12:0] SIZE_CAP = (MAX_SIZE > 8191) ? 13'd8191 : 13'(MAX_SIZE);
	localparam logic [56:0] PIX_ONE  = 57'h1_0000_0000;

	logic [12:0]           width_q, height_q;
	logic [23:0]           scale_q;
	logic [15:0]           cos_q;
	logic                  en;
	logic                  out_valid_q;
	logic [47:0]           out_data_q;
	logic                  out_has_q;

	tri_ctl_t              gctl;
	logic [3:0][1:0][56:0] grad;
	logic [3:0][2:0][31:0] tri_u;
	logic                  t_valid;
	logic [3:0]            t_exist;
	tri_ctl_t              actl;
	logic                  a_valid, a_has;
	logic [2:0][33:0]      a_acc;
	logic                  f_valid;
	logic [2:0][31:0]      f_u;
	logic                  f_has;

	// Round half away from zero to Q1.15 and saturate
	function automatic logic [15:0] to_q15(logic [31:0] u);
		logic [31:0] m;
		logic [16:0] q;
		m = u[31] ? (32'd0 - u) : u;
		q = 17'((m + 32'd16384) >> 15);
		if (!u[31]) begin
			return (q > 17'd32767) ? 16'd32767 : q[15:0];
		end
		if (q > 17'd32768) begin
			q = 17'd32768;
		end
		return 16'(17'd0 - q);
	endfunction

	// Advance the pipeline unless the output register is held
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd4096;
			height_q <= 13'd4096;
			scale_q  <= 24'd65536;
			cos_q    <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WIDTH: begin
					width_q <= (cfg_wdata[12:0] > SIZE_CAP) ? SIZE_CAP : cfg_wdata[12:0];
				end
				CFG_HEIGHT: begin
					height_q <= (cfg_wdata[12:0] > SIZE_CAP) ? SIZE_CAP : cfg_wdata[12:0];
				end
				CFG_SCALE: begin
					scale_q <= cfg_wdata;
				end
				CFG_COS: begin
					cos_q <= cfg_wdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Gradients and triangle vectors
	hne_grad u_grad (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_axis_tvalid & s_axis_tready),
		.col            (s_axis_tdata[11:0]),
		.row            (s_axis_tdata[23:12]),
		.z_center       (s_axis_tdata[55:24]),
		.z_up           (s_axis_tdata[87:56]),
		.z_down         (s_axis_tdata[119:88]),
		.z_left         (s_axis_tdata[151:120]),
		.z_right        (s_axis_tdata[183:152]),
		.image_width    (width_q),
		.image_height   (height_q),
		.vertical_scale (scale_q),
		.ctl_o          (gctl),
		.grad_o         (grad)
	);

	// Triangle normalizers; the first one carries the pixel control
	hne_unit #(.IW(57), .SW(4)) u_tri0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (gctl.valid),
		.in_v      ({PIX_ONE, grad[0][1], grad[0][0]}),
		.in_side   (gctl.exist),
		.out_valid (t_valid),
		.out_u     (tri_u[0]),
		.out_nz    (),
		.out_side  (t_exist)
	);

	for (genvar j = 1; j < 4; j++) begin : g_tri
		hne_unit #(.IW(57), .SW(4)) u_tri (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (gctl.valid),
			.in_v      ({PIX_ONE, grad[j][1], grad[j][0]}),
			.in_side   (gctl.exist),
			.out_valid (),
			.out_u     (tri_u[j]),
			.out_nz    (),
			.out_side  ()
		);
	end

	assign actl.valid = t_valid;
	assign actl.exist = t_exist;

	// Running sum with the discontinuity test
	hne_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_i      (actl),
		.tri_u      (tri_u),
		.min_cosine (cos_q),
		.out_valid  (a_valid),
		.out_has    (a_has),
		.out_acc    (a_acc)
	);

	// Normalize the sum
	hne_unit #(.IW(34), .SW(1)) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (a_valid),
		.in_v      (a_acc),
		.in_side   (a_has),
		.out_valid (f_valid),
		.out_u     (f_u),
		.out_nz    (),
		.out_side  (f_has)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (f_has) begin
				out_data_q <= {to_q15(f_u[2]), to_q15(f_u[1]), to_q15(f_u[0])};
			end else begin
				out_data_q <= '0;
			end
			out_has_q <= f_has;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_has_q;

	// A pixel with no triangle gives an all-zero normal
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("normal without triangle is not zero");

	// Every triangle points up, so the sum keeps a nonnegative z
	a_z_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[47])
		else $error("normal z is negative");

	// Input is refused only while a result is held at the output
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a held result");

endmodule
